/* hw/rtl/pctb_pkg.sv */
// types, constants and helpers shared by the token bucket limiter
package pctb_pkg;

	localparam int CLIENT_ENTRIES = 64;
	localparam int IDX_W = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;

	localparam int ADDR_W = 32;
	localparam int TIME_W = 32;
	localparam int RATE_W = 16;
	localparam int TOK_W = 22;
	localparam int SECS_W = 6;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [TOK_W-1:0] UNITS_PER_TOKEN = 22'd60;
	localparam logic [SECS_W-1:0] MAX_ELAPSED = 6'd60;

	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REQUESTS_PER_MINUTE = 1'd1;

	localparam logic [1:0] STATUS_ALLOWED = 2'd0;
	localparam logic [1:0] STATUS_DISABLED = 2'd1;
	localparam logic [1:0] STATUS_NO_TOKENS = 2'd2;
	localparam logic [1:0] STATUS_FULL = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_SELECT,
		S_READ,
		S_CALC1,
		S_CALC2,
		S_FINISH,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic load_in;
		logic search;
		logic select;
		logic read;
		logic calc1;
		logic calc2;
		logic finish;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic limit_enable;
		logic hit;
		logic free;
		logic out_space;
	} dp_sts_t;

	// lowest set bit of a vector, zero when none
	function automatic logic [IDX_W-1:0] first_set(input logic [CLIENT_ENTRIES-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = CLIENT_ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/pctb_ctrl.sv */
// sequencing state machine of the token bucket limiter
module pctb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pctb_pkg::dp_sts_t sts,
	output pctb_pkg::dp_cmd_t cmd
);
	import pctb_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = sts.limit_enable ? S_MATCH : S_DONE;
				end
			end
			S_MATCH: begin
				cmd.search = 1'b1;
				state_d = S_SELECT;
			end
			S_SELECT: begin
				cmd.select = 1'b1;
				// new client and no free entry: denied at once
				state_d = (!sts.hit && !sts.free) ? S_DONE : S_READ;
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d = S_CALC1;
			end
			S_CALC1: begin
				cmd.calc1 = 1'b1;
				state_d = S_CALC2;
			end
			S_CALC2: begin
				cmd.calc2 = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_space) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/pctb_dp.sv */
// client table, bucket arithmetic, configuration and output register
module pctb_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [pctb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pctb_pkg::CFG_W-1:0]     cfg_data,
	input  logic [pctb_pkg::ADDR_W-1:0]    client_address,
	input  logic [pctb_pkg::TIME_W-1:0]    now_seconds,
	input  pctb_pkg::dp_cmd_t              cmd,
	output pctb_pkg::dp_sts_t              sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           allowed,
	output logic [1:0]                     status
);
	import pctb_pkg::*;

	logic                      limit_enable_q;
	logic [RATE_W-1:0]         rpm_q;

	logic [ADDR_W-1:0]         addr_q;
	logic [TIME_W-1:0]         now_q;
	logic [CLIENT_ENTRIES-1:0] match_q;
	logic [CLIENT_ENTRIES-1:0] free_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      new_q;
	logic [TOK_W-1:0]          rd_tok_q;
	logic [TIME_W-1:0]         rd_last_q;
	logic [TOK_W-1:0]          base_tok_q;
	logic [TIME_W-1:0]         last_base_q;
	logic [TOK_W-1:0]          prod_q;
	logic [TOK_W-1:0]          cap_q;
	logic                      refill_q;
	logic [TOK_W-1:0]          tok2_q;
	logic                      res_allowed_q;
	logic [1:0]                res_status_q;
	logic                      out_valid_q;
	logic                      allowed_q;
	logic [1:0]                status_q;

	logic [CLIENT_ENTRIES-1:0] valid_q;
	logic [ADDR_W-1:0]         addr_tab_q [CLIENT_ENTRIES];
	logic [TOK_W-1:0]          tok_mem [CLIENT_ENTRIES];
	logic [TIME_W-1:0]         last_mem [CLIENT_ENTRIES];

	logic                      any_hit;
	logic                      any_free;
	logic [TOK_W-1:0]          cap_c;
	logic [TOK_W-1:0]          base_tok_c;
	logic [TIME_W-1:0]         last_base_c;
	logic [TIME_W-1:0]         diff_c;
	logic                      refill_c;
	logic [SECS_W-1:0]         secs_c;
	logic [TOK_W:0]            sum_c;
	logic [TOK_W-1:0]          tok2_c;
	logic                      enough_c;

	assign any_hit = |match_q;
	assign any_free = |free_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_enable_q <= 1'b0;
			rpm_q <= RATE_W'(60);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_LIMIT_ENABLE:        limit_enable_q <= cfg_data[0];
				REG_REQUESTS_PER_MINUTE: rpm_q <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// input capture, parallel address compare over the table and entry select
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			addr_q <= client_address;
			now_q <= now_seconds;
		end
		if (cmd.search) begin
			for (int i = 0; i < CLIENT_ENTRIES; i++) begin
				match_q[i] <= valid_q[i] && (addr_tab_q[i] == addr_q);
			end
			free_q <= ~valid_q;
		end
		if (cmd.select) begin
			idx_q <= any_hit ? first_set(match_q) : first_set(free_q);
			new_q <= !any_hit;
		end
	end

	// bucket state memories
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_tok_q <= tok_mem[idx_q];
			rd_last_q <= last_mem[idx_q];
		end
		if (cmd.finish) begin
			tok_mem[idx_q] <= enough_c ? (tok2_q - UNITS_PER_TOKEN) : tok2_q;
			last_mem[idx_q] <= refill_q ? now_q : last_base_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.finish && new_q) begin
			valid_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && new_q) begin
			addr_tab_q[idx_q] <= addr_q;
		end
	end

	// refill arithmetic
	always_comb begin
		cap_c = TOK_W'(rpm_q) * UNITS_PER_TOKEN;
		base_tok_c = new_q ? cap_c : rd_tok_q;
		last_base_c = new_q ? now_q : rd_last_q;
		diff_c = now_q - last_base_c;
		// positive as a signed difference
		refill_c = (diff_c != '0) && !diff_c[TIME_W-1];
		secs_c = (diff_c > TIME_W'(MAX_ELAPSED)) ? MAX_ELAPSED : diff_c[SECS_W-1:0];
		sum_c = {1'b0, base_tok_q} + {1'b0, prod_q};
		if (refill_q) begin
			tok2_c = (sum_c > {1'b0, cap_q}) ? cap_q : sum_c[TOK_W-1:0];
		end else begin
			tok2_c = base_tok_q;
		end
		enough_c = tok2_q >= UNITS_PER_TOKEN;
	end

	always_ff @(posedge clk) begin
		if (cmd.calc1) begin
			base_tok_q <= base_tok_c;
			last_base_q <= last_base_c;
			cap_q <= cap_c;
			refill_q <= refill_c;
			prod_q <= TOK_W'(secs_c) * TOK_W'(rpm_q);
		end
		if (cmd.calc2) begin
			tok2_q <= tok2_c;
		end
	end

	// result held until the output register has room
	always_ff @(posedge clk) begin
		if (cmd.load_in && !limit_enable_q) begin
			res_allowed_q <= 1'b1;
			res_status_q <= STATUS_DISABLED;
		end else if (cmd.select && !any_hit && !any_free) begin
			res_allowed_q <= 1'b0;
			res_status_q <= STATUS_FULL;
		end else if (cmd.finish) begin
			res_allowed_q <= enough_c;
			res_status_q <= enough_c ? STATUS_ALLOWED : STATUS_NO_TOKENS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			allowed_q <= res_allowed_q;
			status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign allowed = allowed_q;
	assign status = status_q;

	assign sts.limit_enable = limit_enable_q;
	assign sts.hit = any_hit;
	assign sts.free = any_free;
	assign sts.out_space = !out_valid_q || out_ready;

endmodule

/* hw/rtl/per_client_token_bucket.sv */
// top level of the per-client token bucket request limiter
// One request at a time: a word is taken in the idle state and its result reaches the
// output register at the end of the controller's sequence (straight from the idle state
// when limiting is disabled, right after the select when the table is full), provided
// the output register has room; the next word is taken in the cycle after that, and a
// request whose result must wait for room is held until the output is read. The output
// register lets a finished result wait while the next request is accepted and worked on.
// The controller's sequence is a parallel compare of the address against all table
// entries, a priority encode, a read of the bucket memories, two arithmetic steps and a
// write-back. The table starts empty after reset and holds CLIENT_ENTRIES clients;
// configuration may be written only while no request is in flight.
module per_client_token_bucket (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [pctb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pctb_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pctb_pkg::ADDR_W-1:0]    client_address,
	input  logic [pctb_pkg::TIME_W-1:0]    now_seconds,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           allowed,
	output logic [1:0]                     status
);
	import pctb_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	pctb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pctb_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.client_address (client_address),
		.now_seconds    (now_seconds),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.allowed        (allowed),
		.status         (status)
	);

	// one word in flight: no second accept straight after the first
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in flight");

	// at most one datapath step per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("controller issued more than one datapath command");

	// the output register is only loaded when it has room
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_space)
		else $error("result loaded over an unread result");

	// allowed flag agrees with the status code
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (allowed == (status == STATUS_ALLOWED || status == STATUS_DISABLED)))
		else $error("allowed flag and status disagree");

endmodule
